### design/kwg_pkg.sv
// Shared constants, widths and types of the Kaiser window generator.
// No dependencies; every other file of the block imports this package.
package kwg_pkg;

  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned SERIES_TERMS = 48;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned BETA_W     = 13;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned NM_W   = 2 * IDX_W;
  localparam int unsigned R_W    = 31;
  localparam int unsigned B2_W   = 2 * BETA_W;
  localparam int unsigned U_W    = 40;
  localparam int unsigned UH_W   = 20;
  localparam int unsigned D_W    = 12;
  localparam int unsigned XB_W   = UH_W + D_W;
  localparam int unsigned RCP_W  = 33;
  localparam int unsigned SH_W   = 6;
  localparam int unsigned T_W    = 64;
  localparam int unsigned C_W    = 40;
  localparam int unsigned PP_W   = 52;
  localparam int unsigned ND_W   = 47;
  localparam int unsigned NS_W   = 5;
  localparam int unsigned NORM_MAX = T_W - ND_W;
  localparam int unsigned X_W    = 63;
  localparam int unsigned XL_W   = 16;
  localparam int unsigned Q_W    = 16;
  localparam int unsigned BES_CELLS = SERIES_TERMS - 1;
  localparam int unsigned RDIV_CELLS = R_W;
  localparam int unsigned QDIV_CELLS = Q_W;

  localparam logic [BETA_W-1:0] BETA_RESET = 13'd3584;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd64;
  localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(MAX_LEN);
  localparam logic [COEF_W-1:0] COEF_ONE   = 16'd32768;
  localparam logic [T_W-1:0]    TERM_ONE   = 64'h0000_0000_0010_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA   = 1'b0,
    REG_LENGTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             oor;
    logic             unity;
  } tag_t;

  typedef logic [1:0][U_W-1:0] lane_u_t;
  typedef logic [1:0][T_W-1:0] lane_w_t;

endpackage

### design/kwg_if.sv
// Handshake channels of the Kaiser window generator: config, index request, result.
// Depends on kwg_pkg for field widths.
interface kwg_cfg_if;
  import kwg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface kwg_in_if;
  import kwg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;
  modport source (output valid, sample_index, input ready);
  modport sink (input valid, sample_index, output ready);
endinterface

interface kwg_out_if;
  import kwg_pkg::*;
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic [IDX_W-1:0]  echo_index;
  logic              out_of_range;
  modport source (output valid, coefficient, echo_index, out_of_range, input ready);
  modport sink (input valid, coefficient, echo_index, out_of_range, output ready);
endinterface

### design/kaiser_window_generator.sv
// Top level of the Kaiser window coefficient generator.
// Depends on kwg_pkg, kwg_if, kwg_rdiv_cell, kwg_bessel_cell and kwg_qdiv_cell.
//
// Usage:
//   cfg_i  : register writes, index REG_BETA (beta, unsigned Q5.8) or REG_LENGTH
//            (window length, saturated to 1024). Always ready; write only while idle.
//   req_i  : one window index per request.
//   rsp_o  : coefficient (unsigned Q1.15, 32768 = 1.0), the echoed index and an
//            out-of-range flag (index not below length, coefficient then 0).
// Throughput is one request per cycle while rsp_o is not held. The accepting edge
// loads the input stage; behind it follow 31 position divider cells, 2 multiply
// stages, 47 series cells of 6 stages each, 1 scaling stage, 16 ratio divider
// cells and the output register, which drives rsp_o.
// Most of the pipeline depth lies in the series cell chain.
// Every stage advances together; when rsp_o is held, the whole pipeline and
// req_i.ready hold as well, and a request is taken again as soon as the output
// register moves. Reset empties the pipeline and loads beta 14.0 and length 64.
module kaiser_window_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  kwg_cfg_if.sink    cfg_i,
  kwg_in_if.sink     req_i,
  kwg_out_if.source  rsp_o
);
  import kwg_pkg::*;

  logic [BETA_W-1:0] beta_q;
  logic [LEN_W-1:0]  len_q;
  logic              adv;

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
      len_q  <= LEN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_BETA:   beta_q <= cfg_i.data[BETA_W-1:0];
        REG_LENGTH: len_q  <= cfg_i.data[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  // front stage
  logic              out_valid_q;
  tag_t              f_tag_d, f_tag_q;
  logic [NM_W-1:0]   f_nm_d, f_nm_q;
  logic [NM_W-1:0]   f_dd_d, f_dd_q;
  logic [B2_W-1:0]   f_b2_d, f_b2_q;

  assign adv         = !out_valid_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_comb begin
    logic [LEN_W-1:0] len_eff;
    logic [IDX_W-1:0] m;
    logic             normal;
    len_eff         = (len_q > LEN_LIMIT) ? LEN_LIMIT : len_q;
    m               = IDX_W'(len_eff - LEN_W'(1));
    f_tag_d.valid   = req_i.valid;
    f_tag_d.idx     = req_i.sample_index;
    f_tag_d.oor     = {1'b0, req_i.sample_index} >= len_eff;
    f_tag_d.unity   = !f_tag_d.oor && (len_eff <= LEN_W'(1));
    normal          = !f_tag_d.oor && !f_tag_d.unity;
    if (normal) begin
      f_nm_d = NM_W'(req_i.sample_index) * NM_W'(m - req_i.sample_index);
      f_dd_d = NM_W'(m) * NM_W'(m);
    end else begin
      f_nm_d = '0;
      f_dd_d = NM_W'(1);
    end
    f_b2_d = B2_W'(beta_q) * B2_W'(beta_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_tag_q <= '0;
    end else if (adv) begin
      f_tag_q <= f_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_nm_q <= f_nm_d;
      f_dd_q <= f_dd_d;
      f_b2_q <= f_b2_d;
    end
  end

  // position divider chain
  tag_t            rd_tag [0:RDIV_CELLS];
  logic [NM_W-1:0] rd_rem [0:RDIV_CELLS];
  logic [NM_W-1:0] rd_dd  [0:RDIV_CELLS];
  logic [R_W-1:0]  rd_q   [0:RDIV_CELLS];
  logic [B2_W-1:0] rd_b2  [0:RDIV_CELLS];

  assign rd_tag[0] = f_tag_q;
  assign rd_rem[0] = {f_nm_q[NM_W-2:0], 1'b0};
  assign rd_dd[0]  = f_dd_q;
  assign rd_q[0]   = '0;
  assign rd_b2[0]  = f_b2_q;

  for (genvar i = 0; i < RDIV_CELLS; i++) begin : g_rdiv
    kwg_rdiv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tag_i  (rd_tag[i]),
      .rem_i  (rd_rem[i]),
      .dd_i   (rd_dd[i]),
      .q_i    (rd_q[i]),
      .b2_i   (rd_b2[i]),
      .tag_o  (rd_tag[i+1]),
      .rem_o  (rd_rem[i+1]),
      .dd_o   (rd_dd[i+1]),
      .q_o    (rd_q[i+1]),
      .b2_o   (rd_b2[i+1])
    );
  end

  // series argument: u = b2 * r / 2^16, denominator u = b2 * 2^14
  tag_t               mu_tag_q, u_tag_q;
  logic [B2_W+15:0]   plo_q;
  logic [B2_W+14:0]   phi_q;
  logic [B2_W-1:0]    mu_b2_q;
  lane_u_t            u_d, u_q;

  assign u_d[0] = U_W'(phi_q) + U_W'(plo_q >> 16);
  assign u_d[1] = U_W'({mu_b2_q, 14'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_tag_q <= '0;
      u_tag_q  <= '0;
    end else if (adv) begin
      mu_tag_q <= rd_tag[RDIV_CELLS];
      u_tag_q  <= mu_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q   <= (B2_W+16)'(rd_b2[RDIV_CELLS]) * (B2_W+16)'(rd_q[RDIV_CELLS][15:0]);
      phi_q   <= (B2_W+15)'(rd_b2[RDIV_CELLS]) * (B2_W+15)'(rd_q[RDIV_CELLS][R_W-1:16]);
      mu_b2_q <= rd_b2[RDIV_CELLS];
      u_q     <= u_d;
    end
  end

  // series cell chain, lane 0 numerator, lane 1 denominator
  tag_t    bs_tag  [0:BES_CELLS];
  lane_u_t bs_u    [0:BES_CELLS];
  lane_w_t bs_term [0:BES_CELLS];
  lane_w_t bs_sum  [0:BES_CELLS];

  assign bs_tag[0]  = u_tag_q;
  assign bs_u[0]    = u_q;
  assign bs_term[0] = {TERM_ONE, TERM_ONE};
  assign bs_sum[0]  = {TERM_ONE, TERM_ONE};

  for (genvar k = 1; k <= BES_CELLS; k++) begin : g_bes
    localparam int unsigned Dk = k * k;
    localparam int unsigned Lk = $clog2(Dk);
    localparam logic [63:0] Rk = (64'd1 << (32 + Lk)) / 64'(Dk);

    kwg_bessel_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .d_i     (D_W'(Dk)),
      .shift_i (SH_W'(32 + Lk)),
      .recip_i (Rk[RCP_W-1:0]),
      .tag_i   (bs_tag[k-1]),
      .u_i     (bs_u[k-1]),
      .term_i  (bs_term[k-1]),
      .sum_i   (bs_sum[k-1]),
      .tag_o   (bs_tag[k]),
      .u_o     (bs_u[k]),
      .term_o  (bs_term[k]),
      .sum_o   (bs_sum[k])
    );
  end

  // scale both sums until the denominator is below 2^47
  tag_t            nz_tag_q;
  logic [ND_W-1:0] nz_rem_d, nz_rem_q;
  logic [ND_W-1:0] nz_den_d, nz_den_q;
  logic [XL_W-1:0] nz_xl_d, nz_xl_q;

  always_comb begin
    logic [NS_W-1:0] nsh;
    logic [T_W-1:0]  num_s;
    logic [T_W-1:0]  den_s;
    logic [X_W-1:0]  x;
    nsh = '0;
    for (int i = 1; i <= NORM_MAX; i++) begin
      if (bs_sum[BES_CELLS][1][ND_W-1+i]) begin
        nsh = NS_W'(i);
      end
    end
    num_s    = bs_sum[BES_CELLS][0] >> nsh;
    den_s    = bs_sum[BES_CELLS][1] >> nsh;
    x        = X_W'({num_s[ND_W-1:0], 15'b0}) + X_W'(den_s[ND_W-1:1]);
    nz_rem_d = x[X_W-1:XL_W];
    nz_xl_d  = x[XL_W-1:0];
    nz_den_d = den_s[ND_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_tag_q <= '0;
    end else if (adv) begin
      nz_tag_q <= bs_tag[BES_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nz_rem_q <= nz_rem_d;
      nz_den_q <= nz_den_d;
      nz_xl_q  <= nz_xl_d;
    end
  end

  // ratio divider chain
  tag_t            qd_tag [0:QDIV_CELLS];
  logic [ND_W-1:0] qd_rem [0:QDIV_CELLS];
  logic [ND_W-1:0] qd_den [0:QDIV_CELLS];
  logic [XL_W-1:0] qd_xl  [0:QDIV_CELLS];
  logic [Q_W-1:0]  qd_q   [0:QDIV_CELLS];

  assign qd_tag[0] = nz_tag_q;
  assign qd_rem[0] = nz_rem_q;
  assign qd_den[0] = nz_den_q;
  assign qd_xl[0]  = nz_xl_q;
  assign qd_q[0]   = '0;

  for (genvar j = 0; j < QDIV_CELLS; j++) begin : g_qdiv
    kwg_qdiv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tag_i  (qd_tag[j]),
      .rem_i  (qd_rem[j]),
      .den_i  (qd_den[j]),
      .xl_i   (qd_xl[j]),
      .q_i    (qd_q[j]),
      .tag_o  (qd_tag[j+1]),
      .rem_o  (qd_rem[j+1]),
      .den_o  (qd_den[j+1]),
      .xl_o   (qd_xl[j+1]),
      .q_o    (qd_q[j+1])
    );
  end

  // output register
  tag_t              last_tag;
  logic [COEF_W-1:0] coef_d, coef_q;
  logic [IDX_W-1:0]  idx_q;
  logic              oor_q;

  assign last_tag = qd_tag[QDIV_CELLS];

  always_comb begin
    if (last_tag.oor) begin
      coef_d = '0;
    end else if (last_tag.unity) begin
      coef_d = COEF_ONE;
    end else if (qd_q[QDIV_CELLS] > COEF_ONE) begin
      coef_d = COEF_ONE;
    end else begin
      coef_d = qd_q[QDIV_CELLS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      coef_q <= coef_d;
      idx_q  <= last_tag.idx;
      oor_q  <= last_tag.oor;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.coefficient  = coef_q;
  assign rsp_o.echo_index   = idx_q;
  assign rsp_o.out_of_range = oor_q;

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.out_of_range |-> rsp_o.coefficient == '0)
    else $error("out-of-range result carries a nonzero coefficient");

  a_coef_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.coefficient <= COEF_ONE)
    else $error("coefficient above 1.0");

  a_stall_blocks_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while the result is held");

  a_len_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready && cfg_i.index == REG_LENGTH
    |=> len_q == $past(cfg_i.data[LEN_W-1:0]))
    else $error("length register did not take the write");

endmodule

### design/kwg_rdiv_cell.sv
// One restoring step of the window position divider n*(L-1-n)*2^32 / (L-1)^2.
// Depends on kwg_pkg.
module kwg_rdiv_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  kwg_pkg::tag_t             tag_i,
  input  logic [kwg_pkg::NM_W-1:0]  rem_i,
  input  logic [kwg_pkg::NM_W-1:0]  dd_i,
  input  logic [kwg_pkg::R_W-1:0]   q_i,
  input  logic [kwg_pkg::B2_W-1:0]  b2_i,
  output kwg_pkg::tag_t             tag_o,
  output logic [kwg_pkg::NM_W-1:0]  rem_o,
  output logic [kwg_pkg::NM_W-1:0]  dd_o,
  output logic [kwg_pkg::R_W-1:0]   q_o,
  output logic [kwg_pkg::B2_W-1:0]  b2_o
);
  import kwg_pkg::*;

  logic [NM_W:0] sh;
  logic [NM_W:0] diff;
  logic          take;

  assign sh   = {rem_i, 1'b0};
  assign take = sh >= {1'b0, dd_i};
  assign diff = sh - {1'b0, dd_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (adv_i) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_o <= take ? diff[NM_W-1:0] : sh[NM_W-1:0];
      q_o   <= {q_i[R_W-2:0], take};
      dd_o  <= dd_i;
      b2_o  <= b2_i;
    end
  end

endmodule

### design/kwg_bessel_cell.sv
// One term of the I0 power series for both the numerator and denominator lanes:
// c = floor(u / k^2) by reciprocal, then term = floor(term * c / 2^32), sum += term.
// Depends on kwg_pkg.
module kwg_bessel_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [kwg_pkg::D_W-1:0]    d_i,
  input  logic [kwg_pkg::SH_W-1:0]   shift_i,
  input  logic [kwg_pkg::RCP_W-1:0]  recip_i,
  input  kwg_pkg::tag_t              tag_i,
  input  kwg_pkg::lane_u_t           u_i,
  input  kwg_pkg::lane_w_t           term_i,
  input  kwg_pkg::lane_w_t           sum_i,
  output kwg_pkg::tag_t              tag_o,
  output kwg_pkg::lane_u_t           u_o,
  output kwg_pkg::lane_w_t           term_o,
  output kwg_pkg::lane_w_t           sum_o
);
  import kwg_pkg::*;

  tag_t    tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  lane_u_t u1_q, u2_q, u3_q, u4_q, u5_q;
  lane_w_t term1_q, term2_q, term3_q, term4_q;
  lane_w_t sum1_q, sum2_q, sum3_q, sum4_q, sum5_q;

  logic [1:0][UH_W+RCP_W-1:0] pa_d, pa_q;
  logic [1:0][UH_W-1:0]       qh_d, qh_q, qh3_q;
  logic [1:0][D_W-1:0]        rh_d, rh_q;
  logic [1:0][XB_W+RCP_W-1:0] pb_d, pb_q;
  logic [1:0][XB_W-1:0]       x3_d, x3_q;
  logic [1:0][C_W-1:0]        c_d, c_q;
  logic [1:0][PP_W-1:0]       p11_d, p10_d, p01_d, p00_d;
  logic [1:0][PP_W-1:0]       p11_q, p10_q, p01_q, p00_q;
  lane_w_t                    term_d, sum_d;

  always_comb begin
    logic [UH_W-1:0] qa;
    logic [XB_W-1:0] ra;
    logic [UH_W-1:0] qb;
    logic [XB_W-1:0] rb;
    logic [72:0]     low;
    logic [T_W-1:0]  nt;
    for (int l = 0; l < 2; l++) begin
      pa_d[l] = (UH_W+RCP_W)'(u_i[l][U_W-1:UH_W]) * (UH_W+RCP_W)'(recip_i);

      qa = UH_W'(pa_q[l] >> shift_i);
      ra = XB_W'(u1_q[l][U_W-1:UH_W]) - XB_W'(qa) * XB_W'(d_i);
      if (ra >= XB_W'(d_i)) begin
        qh_d[l] = qa + UH_W'(1);
        rh_d[l] = D_W'(ra - XB_W'(d_i));
      end else begin
        qh_d[l] = qa;
        rh_d[l] = D_W'(ra);
      end

      x3_d[l] = {rh_q[l], u2_q[l][UH_W-1:0]};
      pb_d[l] = (XB_W+RCP_W)'(x3_d[l]) * (XB_W+RCP_W)'(recip_i);

      qb = UH_W'(pb_q[l] >> shift_i);
      rb = x3_q[l] - XB_W'(qb) * XB_W'(d_i);
      if (rb >= XB_W'(d_i)) begin
        qb = qb + UH_W'(1);
      end
      c_d[l] = {qh3_q[l], qb};

      p11_d[l] = PP_W'(term4_q[l][T_W-1:32]) * PP_W'(c_q[l][C_W-1:UH_W]);
      p10_d[l] = PP_W'(term4_q[l][T_W-1:32]) * PP_W'(c_q[l][UH_W-1:0]);
      p01_d[l] = PP_W'(term4_q[l][31:0]) * PP_W'(c_q[l][C_W-1:UH_W]);
      p00_d[l] = PP_W'(term4_q[l][31:0]) * PP_W'(c_q[l][UH_W-1:0]);

      low       = {p01_q[l], 20'b0} + 73'(p00_q[l]);
      nt        = T_W'({p11_q[l], 20'b0}) + T_W'(p10_q[l]) + T_W'(low[72:32]);
      term_d[l] = nt;
      sum_d[l]  = sum5_q[l] + nt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
      tag_o  <= '0;
    end else if (adv_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      tag5_q <= tag4_q;
      tag_o  <= tag5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q    <= pa_d;
      u1_q    <= u_i;
      term1_q <= term_i;
      sum1_q  <= sum_i;

      qh_q    <= qh_d;
      rh_q    <= rh_d;
      u2_q    <= u1_q;
      term2_q <= term1_q;
      sum2_q  <= sum1_q;

      pb_q    <= pb_d;
      x3_q    <= x3_d;
      qh3_q   <= qh_q;
      u3_q    <= u2_q;
      term3_q <= term2_q;
      sum3_q  <= sum2_q;

      c_q     <= c_d;
      u4_q    <= u3_q;
      term4_q <= term3_q;
      sum4_q  <= sum3_q;

      p11_q   <= p11_d;
      p10_q   <= p10_d;
      p01_q   <= p01_d;
      p00_q   <= p00_d;
      u5_q    <= u4_q;
      sum5_q  <= sum4_q;

      u_o     <= u5_q;
      term_o  <= term_d;
      sum_o   <= sum_d;
    end
  end

endmodule

### design/kwg_qdiv_cell.sv
// One restoring step of the final ratio (num * 2^15 + den / 2) / den.
// Depends on kwg_pkg.
module kwg_qdiv_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  kwg_pkg::tag_t             tag_i,
  input  logic [kwg_pkg::ND_W-1:0]  rem_i,
  input  logic [kwg_pkg::ND_W-1:0]  den_i,
  input  logic [kwg_pkg::XL_W-1:0]  xl_i,
  input  logic [kwg_pkg::Q_W-1:0]   q_i,
  output kwg_pkg::tag_t             tag_o,
  output logic [kwg_pkg::ND_W-1:0]  rem_o,
  output logic [kwg_pkg::ND_W-1:0]  den_o,
  output logic [kwg_pkg::XL_W-1:0]  xl_o,
  output logic [kwg_pkg::Q_W-1:0]   q_o
);
  import kwg_pkg::*;

  logic [ND_W:0] sh;
  logic [ND_W:0] diff;
  logic          take;

  assign sh   = {rem_i, xl_i[XL_W-1]};
  assign take = sh >= {1'b0, den_i};
  assign diff = sh - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (adv_i) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_o <= take ? diff[ND_W-1:0] : sh[ND_W-1:0];
      q_o   <= {q_i[Q_W-2:0], take};
      xl_o  <= {xl_i[XL_W-2:0], 1'b0};
      den_o <= den_i;
    end
  end

endmodule

### dv/kwg_tb_if.sv
// Shared testbench types of the Kaiser window generator: the expected response record.
// Depends on kwg_pkg.
package kwg_tb_pkg;
  import kwg_pkg::*;

  typedef struct {
    logic [COEF_W-1:0] coefficient;
    logic [IDX_W-1:0]  echo_index;
    logic              out_of_range;
  } coef_rsp_t;
endpackage

### dv/tb_kaiser_window_generator.sv
// Testbench of the Kaiser window generator: drives register writes and index requests,
// predicts each coefficient in fixed point and compares every response in order.
// Depends on kwg_pkg, kwg_tb_pkg, kwg_if and the design top level.
module tb_kaiser_window_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import kwg_pkg::*;
  import kwg_tb_pkg::*;

  localparam int unsigned LATENCY = 333;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  kwg_cfg_if cfg_ch ();
  kwg_in_if  req_ch ();
  kwg_out_if rsp_ch ();

  kaiser_window_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  logic [BETA_W-1:0] beta_cur = BETA_RESET;
  logic [LEN_W-1:0]  len_cur  = LEN_RESET;
  coef_rsp_t coef_q[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] mul_shr32(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[95:32];
  endfunction

  function automatic logic [63:0] bessel_q20(logic [63:0] u);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 20;
    sum = term;
    for (int unsigned k = 1; k < SERIES_TERMS; k++) begin
      term = mul_shr32(term, u / (k * k));
      sum += term;
    end
    return sum;
  endfunction

  function automatic coef_rsp_t predict_coef(logic [IDX_W-1:0] n);
    coef_rsp_t res;
    logic [63:0] len, m, nm, r, b2, num, den, q;
    len = len_cur;
    if (len > MAX_LEN) len = MAX_LEN;
    res.echo_index = n;
    res.out_of_range = 1'b0;
    if (n >= len) begin
      res.coefficient = '0;
      res.out_of_range = 1'b1;
    end else if (len <= 1) begin
      res.coefficient = COEF_ONE;
    end else begin
      m = len - 1;
      nm = n * (m - n);
      r = (nm << 32) / (m * m);
      b2 = beta_cur * beta_cur;
      num = bessel_q20((b2 * r) >> 16);
      den = bessel_q20(b2 << 14);
      while (den >= (64'd1 << 47)) begin
        num >>= 1;
        den >>= 1;
      end
      q = ((num << 15) + (den >> 1)) / den;
      if (q > 32768) q = 32768;
      res.coefficient = q[COEF_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == REG_BETA) beta_cur = value[BETA_W-1:0];
    else len_cur = value[LEN_W-1:0];
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_index(int unsigned n, bit gaps = 1'b1);
    int unsigned pause;
    pause = gaps ? $urandom_range(0, 9) : 0;
    repeat (pause) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.sample_index <= n[IDX_W-1:0];
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    coef_q.push_back(predict_coef(n[IDX_W-1:0]));
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned beta, int unsigned len);
    drain();
    write_reg(REG_BETA, beta);
    write_reg(REG_LENGTH, len);
  endtask

  // consumer side with random stalls
  int unsigned stall_left = 0;
  bit stall_on = 1'b1;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    coef_rsp_t want;
    cycles++;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (stall_on) stall_left = $urandom_range(0, 9);
      if (coef_q.size() == 0) begin
        report_mismatch("unexpected response index", rsp_ch.echo_index, 0);
      end else begin
        want = coef_q.pop_front();
        if (rsp_ch.coefficient !== want.coefficient)
          report_mismatch("coefficient", rsp_ch.coefficient, want.coefficient);
        if (rsp_ch.echo_index !== want.echo_index)
          report_mismatch("echo_index", rsp_ch.echo_index, want.echo_index);
        if (rsp_ch.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", rsp_ch.out_of_range, want.out_of_range);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    for (int unsigned n = 0; n < 66; n += 13) send_index(n);
    send_index(63);
    send_index(1023);
  endtask

  task automatic test_extremes();
    set_config(0, 64);
    send_index(0);
    send_index(31);
    set_config(8191, 1024);
    send_index(0);
    send_index(511);
    send_index(1023);
    set_config(5000, 2047);
    send_index(1023);
    send_index(700);
    set_config(1000, 1);
    send_index(0);
    send_index(1);
    set_config(1000, 0);
    send_index(0);
    send_index(1023);
    set_config(256, 2);
    send_index(0);
    send_index(1);
    send_index(2);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned len, n;
    for (int unsigned s = 0; s < 8; s++) begin
      case (s % 4)
        0: set_config($urandom_range(0, 8191), $urandom_range(2, 1024));
        1: set_config($urandom_range(0, 8191), $urandom_range(0, 2047));
        2: set_config($urandom_range(0, 8191), $urandom_range(2, 40));
        default: set_config($urandom_range(1, 8191), 1024);
      endcase
      stall_on = (s != 3);
      len = len_cur > MAX_LEN ? MAX_LEN : len_cur;
      for (int unsigned i = 0; i < count / 8; i++) begin
        if (len != 0 && $urandom_range(0, 9) != 0) n = $urandom_range(0, len - 1);
        else n = $urandom_range(0, 1023);
        send_index(n, s != 5);
      end
    end
    stall_on = 1'b1;
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BETA;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.sample_index = '0;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_random(1232);
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
